// ===== rtl/plcm_pkg.sv =====
// Shared types and constants for the piecewise-linear color map.
// No dependencies; imported by every module of the block but plcm_ram.
`timescale 1ns / 1ps
`default_nettype none

package plcm_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 24;

    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 5'd2;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/plcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/plcm_queue.sv =====
// Two-entry queue that decouples the search front from the divide back.
// Depends on plcm_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module plcm_queue
    import plcm_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output t_q_status             o_status
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;

    assign o_data          = r_slot[r_rd];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plcm_front.sv =====
// Front part: accepts words, loads the table, searches the breakpoints.
// Depends on plcm_pkg; drives the table RAM and pushes jobs into the queue.
`timescale 1ns / 1ps
`default_nettype none

module plcm_front
    import plcm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int AW  = $clog2(MAX_ENTRIES),
    localparam int DW  = VALUE_WIDTH + 1,
    localparam int JW  = 1 + 2 * COLOR_W + 3 * DW,
    localparam int EW  = VALUE_WIDTH + COLOR_W
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [CNT_W-1:0]              i_entry_count,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic [IDX_W-1:0]              i_entry_index,
    input  wire logic signed [VALUE_WIDTH-1:0] i_breakpoint,
    input  wire logic [CH_W-1:0]               i_entry_red,
    input  wire logic [CH_W-1:0]               i_entry_green,
    input  wire logic [CH_W-1:0]               i_entry_blue,
    input  wire logic signed [VALUE_WIDTH-1:0] i_sample_value,
    output logic                               o_ram_we,
    output logic [AW-1:0]                      o_ram_waddr,
    output logic [EW-1:0]                      o_ram_wdata,
    output logic [AW-1:0]                      o_ram_raddr,
    input  wire logic [EW-1:0]                 i_ram_rdata,
    output logic                               o_push,
    output logic [JW-1:0]                      o_job,
    input  wire t_q_status                     i_q_status
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > CNT_W) ? NW : CNT_W;
    // One spare bit so that MAX_ENTRIES itself fits for the range check.
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REQ,
        S_CHK,
        S_PUSH
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_idx;
    logic [NW-1:0]                  r_n;
    logic signed [VALUE_WIDTH-1:0]  r_v;
    logic signed [VALUE_WIDTH-1:0]  r_prev_b;
    logic [COLOR_W-1:0]             r_prev_c;
    logic [JW-1:0]                  r_job;

    logic                           accept;
    logic [XW-1:0]                  widx;
    logic [CW-1:0]                  cnt_x;
    logic [CW-1:0]                  max_x;
    logic [CW-1:0]                  n_eff;
    logic signed [VALUE_WIDTH-1:0]  rd_b;
    logic [COLOR_W-1:0]             rd_c;
    logic [NW-1:0]                  idx_next;
    logic signed [DW-1:0]           v_x;
    logic signed [DW-1:0]           b_x;
    logic signed [DW-1:0]           lo_x;
    logic signed [DW-1:0]           wlo;
    logic signed [DW-1:0]           whi;
    logic signed [DW-1:0]           span;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    assign widx        = XW'(i_entry_index);
    assign o_ram_we    = accept && (i_command == CMD_WRITE) && (widx < XW'(MAX_ENTRIES));
    assign o_ram_waddr = widx[AW-1:0];
    assign o_ram_wdata = {i_breakpoint, i_entry_red, i_entry_green, i_entry_blue};
    assign o_ram_raddr = r_idx;

    assign cnt_x = CW'(i_entry_count);
    assign max_x = CW'(MAX_ENTRIES);
    assign n_eff = (cnt_x < CW'(2)) ? CW'(2) : ((cnt_x > max_x) ? max_x : cnt_x);

    assign rd_b     = i_ram_rdata[EW-1:COLOR_W];
    assign rd_c     = i_ram_rdata[COLOR_W-1:0];
    assign idx_next = NW'(r_idx) + NW'(1);

    assign v_x  = DW'(r_v);
    assign b_x  = DW'(rd_b);
    assign lo_x = DW'(r_prev_b);
    assign wlo  = b_x - v_x;
    assign whi  = v_x - lo_x;
    assign span = b_x - lo_x;

    assign o_push = (r_state == S_PUSH) && !i_q_status.full;
    assign o_job  = r_job;

    // A job carries a direct flag; a direct job outputs its second color as is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_command == CMD_MAP)) begin
                        r_v     <= i_sample_value;
                        r_n     <= NW'(n_eff);
                        r_idx   <= '0;
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_prev_b <= rd_b;
                    r_prev_c <= rd_c;
                    if (r_idx == '0) begin
                        if (r_v < rd_b) begin
                            r_job   <= {1'b1, COLOR_W'(0), rd_c, (3 * DW)'(0)};
                            r_state <= S_PUSH;
                        end else begin
                            r_idx   <= AW'(1);
                            r_state <= S_REQ;
                        end
                    end else if (r_v > rd_b) begin
                        if (idx_next >= r_n) begin
                            r_job   <= {1'b1, COLOR_W'(0), rd_c, (3 * DW)'(0)};
                            r_state <= S_PUSH;
                        end else begin
                            r_idx   <= idx_next[AW-1:0];
                            r_state <= S_REQ;
                        end
                    end else if (rd_b <= r_prev_b) begin
                        r_job   <= {1'b1, COLOR_W'(0), rd_c, (3 * DW)'(0)};
                        r_state <= S_PUSH;
                    end else begin
                        r_job   <= {1'b0, r_prev_c, rd_c, wlo, whi, span};
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_status.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plcm_back.sv =====
// Back part: blends the two colors of a job and divides, eight quotient bits.
// Depends on plcm_pkg; pops jobs from the queue and holds the output word.
`timescale 1ns / 1ps
`default_nettype none

module plcm_back
    import plcm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int DW = VALUE_WIDTH + 1,
    localparam int JW = 1 + 2 * COLOR_W + 3 * DW
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [JW-1:0]   i_job,
    input  wire t_q_status       i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue
);

    localparam int PW   = CH_W + DW;
    localparam int NUMW = PW + 1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_DIV,
        B_OUT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_step;
    logic [COLOR_W-1:0] r_c0;
    logic [COLOR_W-1:0] r_c1;
    logic [DW-1:0]      r_wlo;
    logic [DW-1:0]      r_whi;
    logic [DW-1:0]      r_d;
    logic [PW-1:0]      r_p0 [3];
    logic [PW-1:0]      r_p1 [3];
    logic [NUMW-1:0]    r_rem [3];
    logic [NUMW-1:0]    r_dsh;
    logic [CH_W-1:0]    r_q [3];

    logic               job_direct;
    logic [COLOR_W-1:0] job_c0;
    logic [COLOR_W-1:0] job_c1;
    logic [DW-1:0]      job_wlo;
    logic [DW-1:0]      job_whi;
    logic [DW-1:0]      job_d;

    assign {job_direct, job_c0, job_c1, job_wlo, job_whi, job_d} = i_job;

    assign o_pop = (r_state == B_IDLE) && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_q_status.empty) begin
                        if (job_direct) begin
                            o_out_red   <= job_c1[3*CH_W-1:2*CH_W];
                            o_out_green <= job_c1[2*CH_W-1:CH_W];
                            o_out_blue  <= job_c1[CH_W-1:0];
                            o_valid     <= 1'b1;
                            r_state     <= B_OUT;
                        end else begin
                            r_c0    <= job_c0;
                            r_c1    <= job_c1;
                            r_wlo   <= job_wlo;
                            r_whi   <= job_whi;
                            r_d     <= job_d;
                            r_state <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_p0[ch] <= PW'(r_c0[(2-ch)*CH_W +: CH_W]) * PW'(r_wlo);
                        r_p1[ch] <= PW'(r_c1[(2-ch)*CH_W +: CH_W]) * PW'(r_whi);
                    end
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_rem[ch] <= NUMW'(r_p0[ch]) + NUMW'(r_p1[ch]);
                    end
                    r_dsh   <= NUMW'(r_d) << (CH_W - 1);
                    r_step  <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    // Restoring division, most significant quotient bit first.
                    for (int ch = 0; ch < 3; ch++) begin
                        if (r_rem[ch] >= r_dsh) begin
                            r_rem[ch] <= r_rem[ch] - r_dsh;
                            r_q[ch]   <= {r_q[ch][CH_W-2:0], 1'b1};
                        end else begin
                            r_q[ch]   <= {r_q[ch][CH_W-2:0], 1'b0};
                        end
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'(CH_W - 1)) begin
                        r_state <= B_OUT;
                        o_valid <= 1'b1;
                    end
                end
                B_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
            if (r_state == B_DIV && r_step == 3'(CH_W - 1)) begin
                o_out_red   <= (r_rem[0] >= r_dsh) ? {r_q[0][CH_W-2:0], 1'b1}
                                                   : {r_q[0][CH_W-2:0], 1'b0};
                o_out_green <= (r_rem[1] >= r_dsh) ? {r_q[1][CH_W-2:0], 1'b1}
                                                   : {r_q[1][CH_W-2:0], 1'b0};
                o_out_blue  <= (r_rem[2] >= r_dsh) ? {r_q[2][CH_W-2:0], 1'b1}
                                                   : {r_q[2][CH_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_color_map.sv =====
// Top level of the piecewise-linear color map.
// Depends on plcm_pkg, plcm_ram, plcm_queue, plcm_front and plcm_back.
//
// The input channel (i_valid / o_stall) carries one word per command. A write
// word loads one table entry: a signed breakpoint and an RGB color. A map
// word carries a sample value and yields one output word on the result
// channel (o_valid / i_stall) holding the blended color; a write word yields
// nothing. Entries must be written before a map word reads them.
// The number of entries searched is set over the APB port, register 0.
//
// The front searches the table one entry at a time, a read state and a check
// state per entry, out of a RAM with registered read; a write word needs no
// search. The back blends and divides in one multiply step, one add step and
// eight restoring-divide steps; a clamp or zero-interval result skips that.
// A two-entry queue lets the front search the next word while the back
// divides or its output is stalled. Reset clears all control state and sets
// the entry count to 2; the table contents are left as they are. While
// i_stall is high the output word holds and the block keeps taking input
// until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_color_map
    import plcm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic [IDX_W-1:0]              i_entry_index,
    input  wire logic signed [VALUE_WIDTH-1:0] i_breakpoint,
    input  wire logic [CH_W-1:0]               i_entry_red,
    input  wire logic [CH_W-1:0]               i_entry_green,
    input  wire logic [CH_W-1:0]               i_entry_blue,
    input  wire logic signed [VALUE_WIDTH-1:0] i_sample_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [CH_W-1:0]                    o_out_red,
    output logic [CH_W-1:0]                    o_out_green,
    output logic [CH_W-1:0]                    o_out_blue
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int DW = VALUE_WIDTH + 1;
    localparam int JW = 1 + 2 * COLOR_W + 3 * DW;
    localparam int EW = VALUE_WIDTH + COLOR_W;

    logic [CNT_W-1:0] r_entry_count;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic             q_push;
    logic             q_pop;
    logic [JW-1:0]    q_in;
    logic [JW-1:0]    q_out;
    t_q_status        q_status;

    // Configuration register: only the entry count, at byte address 0.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(r_entry_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT)) begin
            r_entry_count <= pwdata[CNT_W-1:0];
        end
    end

    plcm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    plcm_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_count  (r_entry_count),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_entry_index  (i_entry_index),
        .i_breakpoint   (i_breakpoint),
        .i_entry_red    (i_entry_red),
        .i_entry_green  (i_entry_green),
        .i_entry_blue   (i_entry_blue),
        .i_sample_value (i_sample_value),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_push         (q_push),
        .o_job          (q_in),
        .i_q_status     (q_status)
    );

    plcm_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    plcm_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

endmodule

`default_nettype wire

// ===== verif/tb_piecewise_linear_color_map.sv =====
// Self-checking testbench for the piecewise-linear color map.
// Depends on plcm_pkg and the piecewise_linear_color_map RTL.
`timescale 1ns / 1ps

module tb_piecewise_linear_color_map;
    import plcm_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam int NUM_RANDOM = 968;
    localparam int IDLE_LIMIT = 20000;
    // The longest search plus the blend and divide, with margin.
    localparam int DRAIN_CYCLES = 2 * 16 + 40;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    // One row of directed stimulus. A row with has_color set carries a color
    // that can be read straight off the table; other rows use the predictor.
    typedef struct {
        logic                 command;
        logic [IDX_W-1:0]     index;
        logic signed [VW-1:0] value;
        t_color               color;
        logic                 has_color;
        t_color               known_color;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = CMD_MAP;
    logic [IDX_W-1:0] entry_index = '0;
    logic signed [VW-1:0] breakpoint = '0;
    logic [CH_W-1:0] entry_red = '0, entry_green = '0, entry_blue = '0;
    logic signed [VW-1:0] sample_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CH_W-1:0] out_red, out_green, out_blue;

    // The predictor's own copy of the table and the entry count.
    logic signed [VW-1:0] bp_shadow [MAX_ENTRIES_DEF];
    t_color color_shadow [MAX_ENTRIES_DEF];
    int unsigned count_shadow;

    t_color expected_colors[$];
    int errors = 0;
    int idle_cycles = 0;
    bit rand_idle = 1'b1;

    piecewise_linear_color_map dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_command(cmd), .i_entry_index(entry_index), .i_breakpoint(breakpoint),
        .i_entry_red(entry_red), .i_entry_green(entry_green),
        .i_entry_blue(entry_blue), .i_sample_value(sample_value),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_red(out_red), .o_out_green(out_green), .o_out_blue(out_blue)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Blend of colors i-1 and i as the block computes it: the weights are the
    // distances to the opposite breakpoint, and the quotient is truncated.
    function automatic t_color map_sample(logic signed [VW-1:0] v);
        int unsigned n, i;
        longint lo, hi, d, wlo, whi;
        t_color c0, c1, res;
        n = (count_shadow < 2) ? 2 : (count_shadow > MAX_ENTRIES_DEF) ?
            MAX_ENTRIES_DEF : count_shadow;
        if (v < bp_shadow[0]) return color_shadow[0];
        i = 1;
        while (i < n && v > bp_shadow[i]) i++;
        if (i >= n) return color_shadow[n-1];
        lo = bp_shadow[i-1];
        hi = bp_shadow[i];
        if (hi <= lo) return color_shadow[i];
        d = hi - lo;
        wlo = hi - longint'(v);
        whi = longint'(v) - lo;
        c0 = color_shadow[i-1];
        c1 = color_shadow[i];
        res.red   = CH_W'((c0.red   * wlo + c1.red   * whi) / d);
        res.green = CH_W'((c0.green * wlo + c1.green * whi) / d);
        res.blue  = CH_W'((c0.blue  * wlo + c1.blue  * whi) / d);
        return res;
    endfunction

    // Waits with random idle cycles, then presents one word and holds it
    // until the block accepts it. A map word queues its expected color.
    // Valid stays high after the word is taken, so the caller either sends
    // the next word at once or drops valid through drain().
    task automatic send_word(input logic c, input logic [IDX_W-1:0] idx,
                             input logic signed [VW-1:0] value, input t_color col,
                             input logic has_known, input t_color known);
        t_color predicted;
        while (rand_idle && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        entry_index <= idx;
        breakpoint <= (c == CMD_WRITE) ? value : VW'($urandom);
        sample_value <= (c == CMD_MAP) ? value : VW'($urandom);
        entry_red <= col.red;
        entry_green <= col.green;
        entry_blue <= col.blue;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (c == CMD_WRITE) begin
            bp_shadow[idx] = value;
            color_shadow[idx] = col;
        end else begin
            predicted = map_sample(value);
            if (has_known && predicted !== known)
                $display("%0t: table row disagrees with predictor: %h vs %h",
                         $time, known, predicted);
            expected_colors.push_back(has_known ? known : predicted);
        end
        @(negedge clk);
    endtask

    task automatic write_entry_count(input int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_ENTRY_COUNT);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        count_shadow = value & 5'h1F;
    endtask

    // Drops valid, lets every expected word arrive, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes count entries with ascending breakpoints, ties allowed with allow_ties, and random colors.
    task automatic load_sorted(input int unsigned count, input bit allow_ties);
        logic signed [VW-1:0] b;
        t_color col;
        b = -VW'($urandom_range(4000000, 10));
        for (int k = 0; k < count; k++) begin
            col = t_color'($urandom);
            send_word(CMD_WRITE, IDX_W'(k), b, col, 1'b0, '0);
            if (!(allow_ties && $urandom_range(4) == 0))
                b = b + VW'($urandom_range(1000000, 1));
        end
    endtask

    // Output side: random stall, with a clean stretch driven by rand_idle.
    always @(negedge clk) begin
        out_stall <= rand_idle && ($urandom_range(99) < 31);
    end

    // Compares each accepted word with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected word %h %h %h", $time,
                         out_red, out_green, out_blue);
                errors++;
            end else begin
                t_color exp_c;
                exp_c = expected_colors.pop_front();
                if (out_red !== exp_c.red) begin
                    $display("%0t: red expected %h actual %h", $time, exp_c.red, out_red);
                    errors++;
                end
                if (out_green !== exp_c.green) begin
                    $display("%0t: green expected %h actual %h", $time,
                             exp_c.green, out_green);
                    errors++;
                end
                if (out_blue !== exp_c.blue) begin
                    $display("%0t: blue expected %h actual %h", $time,
                             exp_c.blue, out_blue);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_row directed [$];
    localparam t_color RED   = '{8'hFF, 8'h00, 8'h00};
    localparam t_color BLUE  = '{8'h00, 8'h00, 8'hFF};
    localparam t_color WHITE = '{8'hFF, 8'hFF, 8'hFF};
    localparam t_color BLACK = '{8'h00, 8'h00, 8'h00};

    initial begin
        t_row r;
        int unsigned n;
        int unsigned counts [8];
        for (int k = 0; k < MAX_ENTRIES_DEF; k++) begin
            bp_shadow[k] = '0;
            color_shadow[k] = '0;
        end
        count_shadow = ENTRY_COUNT_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table under the reset entry count of two.
        directed = '{
            '{CMD_WRITE, 4'd0, -24'sh7FFFFF - 1, BLACK, 1'b0, BLACK},
            '{CMD_WRITE, 4'd1, 24'sh7FFFFF, WHITE, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, -24'sh7FFFFF - 1, BLACK, 1'b1, BLACK},
            '{CMD_MAP, 4'd0, 24'sh7FFFFF, BLACK, 1'b1, WHITE},
            '{CMD_MAP, 4'd0, 24'sh000000, BLACK, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, -24'sh000001, BLACK, 1'b0, BLACK},
            '{CMD_WRITE, 4'd0, 24'sh000100, RED, 1'b0, BLACK},
            '{CMD_WRITE, 4'd1, 24'sh000200, BLUE, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, 24'sh0000FF, BLACK, 1'b1, RED},
            '{CMD_MAP, 4'd0, 24'sh000201, BLACK, 1'b1, BLUE},
            '{CMD_MAP, 4'd0, 24'sh000180, BLACK, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, 24'sh000100, BLACK, 1'b1, RED},
            '{CMD_MAP, 4'd0, 24'sh000200, BLACK, 1'b1, BLUE},
            '{CMD_WRITE, 4'd1, 24'sh000100, WHITE, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, 24'sh000100, BLACK, 1'b1, WHITE},
            '{CMD_WRITE, 4'd15, 24'sh123456, WHITE, 1'b0, BLACK},
            '{CMD_WRITE, 4'd1, -24'sh000100, BLUE, 1'b0, BLACK},
            '{CMD_MAP, 4'd0, 24'sh000100, BLACK, 1'b0, BLACK}
        };
        foreach (directed[k]) begin
            r = directed[k];
            send_word(r.command, r.index, r.value, r.color, r.has_color, r.known_color);
        end
        drain();

        // Random phases under several entry counts, the extremes among them.
        // Out-of-range counts are written once each to check the saturation.
        counts = '{16, 0, 5, 31, 2, 9, 16, 3};
        foreach (counts[p]) begin
            write_entry_count(counts[p]);
            n = (counts[p] < 2) ? 2 : (counts[p] > 16) ? 16 : counts[p];
            rand_idle = (p != 6);
            // Always load every entry the search may touch.
            load_sorted(n, 1'(p % 2));
            for (int k = 0; k < NUM_RANDOM / 8; k++) begin
                int sel;
                sel = $urandom_range(19);
                if (sel == 0) begin
                    // Noise write: any entry the search may touch, any breakpoint, so tables get unsorted.
                    send_word(CMD_WRITE, IDX_W'($urandom_range(n - 1)), VW'($urandom),
                              t_color'($urandom), 1'b0, '0);
                end else if (sel < 4) begin
                    send_word(CMD_MAP, IDX_W'($urandom), VW'($urandom), '0, 1'b0, '0);
                end else begin
                    // Values near the loaded breakpoints.
                    send_word(CMD_MAP, IDX_W'($urandom),
                              bp_shadow[$urandom_range(n - 1)] +
                              VW'($signed($urandom_range(2000000)) - 1000000),
                              t_color'($urandom), 1'b0, '0);
                end
            end
            drain();
        end

        if (errors == 0 && expected_colors.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plcm_pkg.sv
rtl/plcm_ram.sv
rtl/plcm_queue.sv
rtl/plcm_front.sv
rtl/plcm_back.sv
rtl/piecewise_linear_color_map.sv
verif/tb_piecewise_linear_color_map.sv
